### design/fwoik_pkg.sv
`default_nettype none

package fwoik_pkg;

    // field formats
    localparam int SPEED_W   = 24;
    localparam int LEN_FRAC  = 16;
    localparam int LEN_W     = 16;
    localparam int LIMIT_W   = SPEED_W - 1;
    localparam int MASK_W    = 4;
    localparam int NWHEEL    = 4;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPAN_FB    = 3'd0,
        REG_SPAN_LR    = 3'd1,
        REG_DIAM_FL    = 3'd2,
        REG_DIAM_FR    = 3'd3,
        REG_DIAM_BL    = 3'd4,
        REG_DIAM_BR    = 3'd5,
        REG_INV_MASK   = 3'd6,
        REG_SPEED_LIM  = 3'd7
    } reg_idx_t;

    // internal widths
    localparam int SPAN_W  = LEN_W + 1;
    localparam int SW_W    = SPAN_W + 1 + SPEED_W;
    localparam int LIN_W   = SPEED_W + ((LEN_FRAC > LEN_W) ? LEN_FRAC : LEN_W) + 3;
    localparam int PW      = SPEED_W + LEN_W + 1;
    localparam int ACH_W   = SPEED_W + LEN_W + 3;
    localparam int DN_A    = (LIN_W > ACH_W) ? LIN_W : ACH_W;
    localparam int DN_W    = (DN_A > 2 * SPEED_W) ? DN_A : 2 * SPEED_W;
    localparam int DD_W    = (SPEED_W > LEN_W + 3) ? SPEED_W : LEN_W + 3;
    localparam int QW      = SPEED_W + 1;
    localparam int DIV_LAT = QW + 1;
    localparam int WIDE_W  = DN_W + ACH_W;

    localparam logic [WIDE_W-1:0] MAG_POS = (WIDE_W'(1) << (SPEED_W - 1)) - WIDE_W'(1);
    localparam logic [WIDE_W-1:0] MAG_NEG = WIDE_W'(1) << (SPEED_W - 1);

    // one step of the long division
    typedef struct packed {
        logic [DD_W-1:0] rem;
        logic [QW-1:0]   low;
        logic [QW-1:0]   quo;
        logic [DD_W-1:0] den;
        logic            neg;
        logic            ovf;
        logic            zero;
    } div_st_t;

    typedef struct packed {
        logic [SPEED_W-1:0] val;
        logic               hit;
    } sat_t;

    // signed result from magnitude and sign, clamped to the speed range
    function automatic sat_t sat_mag(input logic [WIDE_W-1:0] m, input logic neg);
        sat_t r;
        r.hit = 1'b0;
        if (neg) begin
            if (m > MAG_NEG) begin
                r.val = SPEED_W'(MAG_NEG);
                r.hit = 1'b1;
            end
            else begin
                r.val = SPEED_W'(-m);
            end
        end
        else begin
            if (m > MAG_POS) begin
                r.val = SPEED_W'(MAG_POS);
                r.hit = 1'b1;
            end
            else begin
                r.val = SPEED_W'(m);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### design/fwoik_cmd_if.sv
`default_nettype none

interface fwoik_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fwoik_pkg::SPEED_W-1:0] forward_speed;
    logic signed [fwoik_pkg::SPEED_W-1:0] sideways_speed;
    logic signed [fwoik_pkg::SPEED_W-1:0] yaw_rate;

    modport source (output valid, forward_speed, sideways_speed, yaw_rate, input ready);
    modport sink (input valid, forward_speed, sideways_speed, yaw_rate, output ready);
endinterface

`default_nettype wire

### design/fwoik_res_if.sv
`default_nettype none

interface fwoik_res_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fwoik_pkg::SPEED_W-1:0] wheel_rate_front_left;
    logic signed [fwoik_pkg::SPEED_W-1:0] wheel_rate_front_right;
    logic signed [fwoik_pkg::SPEED_W-1:0] wheel_rate_back_left;
    logic signed [fwoik_pkg::SPEED_W-1:0] wheel_rate_back_right;
    logic signed [fwoik_pkg::SPEED_W-1:0] achieved_forward;
    logic signed [fwoik_pkg::SPEED_W-1:0] achieved_sideways;
    logic signed [fwoik_pkg::SPEED_W-1:0] achieved_yaw;
    logic                                 was_limited;

    modport source (output valid, wheel_rate_front_left, wheel_rate_front_right,
        wheel_rate_back_left, wheel_rate_back_right, achieved_forward,
        achieved_sideways, achieved_yaw, was_limited, input ready);
    modport sink (input valid, wheel_rate_front_left, wheel_rate_front_right,
        wheel_rate_back_left, wheel_rate_back_right, achieved_forward,
        achieved_sideways, achieved_yaw, was_limited, output ready);
endinterface

`default_nettype wire

### design/fwoik_div.sv
`default_nettype none

// pipelined rounding divider, one quotient bit per stage, saturating result
module fwoik_div (
    input  wire logic                                 clk,
    input  wire logic                                 en,
    input  wire logic [fwoik_pkg::DN_W-1:0]           num,
    input  wire logic [fwoik_pkg::DD_W-1:0]           den,
    input  wire logic                                 neg,
    output logic signed [fwoik_pkg::SPEED_W-1:0]      q,
    output logic                                      hit
);

    localparam int STEPS = fwoik_pkg::QW;
    localparam int NS_W  = fwoik_pkg::DN_W + 1;

    fwoik_pkg::div_st_t st_reg [0:STEPS];

    logic [NS_W-1:0]    nsum;
    logic [NS_W-1:0]    high;
    fwoik_pkg::div_st_t st_first;
    fwoik_pkg::sat_t    res;

    // add half the divisor for rounding, check quotient range
    always_comb
    begin
        nsum               = {1'b0, num} + NS_W'(den >> 1);
        high               = nsum >> STEPS;
        st_first.rem       = fwoik_pkg::DD_W'(high);
        st_first.low       = nsum[STEPS-1:0];
        st_first.quo       = '0;
        st_first.den       = den;
        st_first.neg       = neg;
        st_first.ovf       = (high >= NS_W'(den));
        st_first.zero      = (num == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st_first;
        end
    end

    // one restoring step per stage
    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        logic [fwoik_pkg::DD_W:0] trial;
        logic                     ge;
        fwoik_pkg::div_st_t       st_next;

        always_comb
        begin
            trial       = {st_reg[k].rem, st_reg[k].low[STEPS-1]};
            ge          = (trial >= {1'b0, st_reg[k].den});
            st_next     = st_reg[k];
            st_next.rem = ge ? fwoik_pkg::DD_W'(trial - {1'b0, st_reg[k].den})
                             : fwoik_pkg::DD_W'(trial);
            st_next.low = st_reg[k].low << 1;
            st_next.quo = {st_reg[k].quo[STEPS-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k+1] <= st_next;
            end
        end
    end

    // sign and clamp
    always_comb
    begin
        res = fwoik_pkg::sat_mag(st_reg[STEPS].ovf ? '1 : fwoik_pkg::WIDE_W'(st_reg[STEPS].quo),
                                 st_reg[STEPS].neg);
        if (st_reg[STEPS].zero)
        begin
            q   = '0;
            hit = 1'b0;
        end
        else
        begin
            q   = res.val;
            hit = res.hit;
        end
    end

endmodule

`default_nettype wire

### design/four_wheel_omni_inverse_kinematics.sv
`default_nettype none

// channel  | role   | payload
// cmd      | sink   | forward_speed, sideways_speed, yaw_rate
// res      | source | four wheel rates, achieved body velocity, was_limited
// cfg      | write  | cfg_write, cfg_index, cfg_data
//
// one beat in per cycle while the pipeline is not held; the path passes through
// three chained one-bit-per-stage dividers (wheel, scale, yaw)
// the whole pipeline advances together; it holds while res is full and stalled
// reset clears valid bits and loads the default geometry, inversion mask and limit
module four_wheel_omni_inverse_kinematics (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [fwoik_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fwoik_pkg::CFG_DATA_W-1:0]    cfg_data,
    fwoik_cmd_if.sink                                cmd,
    fwoik_res_if.source                              res
);

    localparam int SW   = fwoik_pkg::SPEED_W;
    localparam int NW   = fwoik_pkg::NWHEEL;
    localparam int DL   = fwoik_pkg::DIV_LAT;
    localparam int LAT  = 3 * DL + 10;
    localparam int ACHW = fwoik_pkg::ACH_W;
    localparam int LINW = fwoik_pkg::LIN_W;
    localparam int SHR  = fwoik_pkg::LEN_FRAC + 3;
    localparam logic [ACHW-1:0] HALF8 = ACHW'(1) << (SHR - 1);

    typedef struct packed {
        logic [NW-1:0][SW-1:0] rate;
        logic                  scl;
        logic                  lim;
    } sdel_t;

    typedef struct packed {
        logic [NW-1:0][SW-1:0] rate;
        logic                  lim;
        logic [SW-1:0]         ax;
        logic [SW-1:0]         ay;
    } ydel_t;

    // configuration
    logic [fwoik_pkg::LEN_W-1:0]   span_fb_reg;
    logic [fwoik_pkg::LEN_W-1:0]   span_lr_reg;
    logic [fwoik_pkg::LEN_W-1:0]   diam_reg [NW];
    logic [fwoik_pkg::MASK_W-1:0]  inv_reg;
    logic [fwoik_pkg::LIMIT_W-1:0] limit_reg;
    logic [fwoik_pkg::SPAN_W-1:0]  span;

    logic           adv;
    logic [LAT-1:0] vld_reg;

    // stage registers
    logic signed [SW-1:0]               fwd_s1_reg, side_s1_reg;
    logic signed [fwoik_pkg::SW_W-1:0]  sw_s1_reg;
    logic signed [fwoik_pkg::SW_W-1:0]  sw_next;
    logic [fwoik_pkg::DN_W-1:0]         wnum_s2_reg [NW];
    logic                               wneg_s2_reg [NW];
    logic signed [LINW-1:0]             lin [NW];
    logic signed [LINW-1:0]             lv, ln, swx;
    logic signed [SW-1:0]               wq [NW];
    logic                               whit [NW];
    logic signed [SW-1:0]               rate_s3_reg [NW];
    logic [SW-1:0]                      arate_s3_reg [NW];
    logic                               lim_s3_reg;
    logic signed [SW-1:0]               rate_s4_reg [NW];
    logic [SW-1:0]                      arate_s4_reg [NW];
    logic [SW-1:0]                      peak_s4_reg;
    logic                               lim_s4_reg;
    logic [SW-1:0]                      max01, max23;
    logic [fwoik_pkg::DN_W-1:0]         prod_s5_reg [NW];
    logic                               sneg_s5_reg [NW];
    logic [SW-1:0]                      peak_s5_reg;
    logic signed [SW-1:0]               rate_s5_reg [NW];
    logic                               scl_s5_reg, lim_s5_reg;
    logic                               scl_next;
    logic signed [SW-1:0]               sq [NW];
    sdel_t                              sd_reg [DL];
    logic signed [SW-1:0]               rate_s6_reg [NW];
    logic                               lim_s6_reg;
    logic signed [fwoik_pkg::PW-1:0]    p_s7_reg [NW];
    logic signed [SW-1:0]               rate_s7_reg [NW];
    logic                               lim_s7_reg;
    logic signed [ACHW-1:0]             t [NW];
    logic signed [ACHW-1:0]             xn_s8_reg, yn_s8_reg, tot_s8_reg;
    logic signed [SW-1:0]               rate_s8_reg [NW];
    logic                               lim_s8_reg;
    logic [ACHW-1:0]                    xm, ym, totm;
    fwoik_pkg::sat_t                    xs, ys;
    logic [SW-1:0]                      ax_s9_reg, ay_s9_reg;
    logic [fwoik_pkg::DN_W-1:0]         ynum_s9_reg;
    logic                               yneg_s9_reg;
    logic signed [SW-1:0]               rate_s9_reg [NW];
    logic                               lim_s9_reg;
    logic signed [SW-1:0]               yq;
    ydel_t                              yd_reg [DL];

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_fb_reg <= 16'd12124;
            span_lr_reg <= 16'd14418;
            for (int i = 0; i < NW; i++)
            begin
                diam_reg[i] <= 16'd3932;
            end
            inv_reg   <= 4'd10;
            limit_reg <= 23'd225280;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fwoik_pkg::REG_SPAN_FB:   span_fb_reg <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_SPAN_LR:   span_lr_reg <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_DIAM_FL:   diam_reg[0] <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_DIAM_FR:   diam_reg[1] <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_DIAM_BL:   diam_reg[2] <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_DIAM_BR:   diam_reg[3] <= fwoik_pkg::LEN_W'(cfg_data);
                fwoik_pkg::REG_INV_MASK:  inv_reg     <= fwoik_pkg::MASK_W'(cfg_data);
                fwoik_pkg::REG_SPEED_LIM: limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    assign span = {1'b0, span_fb_reg} + {1'b0, span_lr_reg};

    // handshake and valid bits
    assign adv       = ~vld_reg[LAT-1] | res.ready;
    assign cmd.ready = adv;
    assign res.valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[LAT-2:0], cmd.valid};
        end
    end

    // stage 1: span times yaw rate
    assign sw_next = $signed({1'b0, span}) * cmd.yaw_rate;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fwd_s1_reg  <= cmd.forward_speed;
            side_s1_reg <= cmd.sideways_speed;
            sw_s1_reg   <= sw_next;
        end
    end

    // stage 2: twice the wheel linear speeds, sign and magnitude
    always_comb
    begin
        lv     = LINW'(fwd_s1_reg) <<< fwoik_pkg::LEN_FRAC;
        ln     = LINW'(side_s1_reg) <<< fwoik_pkg::LEN_FRAC;
        swx    = LINW'(sw_s1_reg);
        lin[0] = ((lv - ln) <<< 1) - swx;
        lin[1] = ((-lv - ln) <<< 1) - swx;
        lin[2] = ((lv + ln) <<< 1) - swx;
        lin[3] = ((ln - lv) <<< 1) - swx;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                wnum_s2_reg[i] <= fwoik_pkg::DN_W'(lin[i][LINW-1] ? LINW'(-lin[i])
                                                                   : lin[i]);
                wneg_s2_reg[i] <= lin[i][LINW-1] ^ inv_reg[i];
            end
        end
    end

    // wheel rate dividers
    for (genvar g = 0; g < NW; g++)
    begin : g_wdiv
        fwoik_div u_wdiv (
            .clk (clk),
            .en  (adv),
            .num (wnum_s2_reg[g]),
            .den (fwoik_pkg::DD_W'(diam_reg[g])),
            .neg (wneg_s2_reg[g]),
            .q   (wq[g]),
            .hit (whit[g])
        );
    end

    // stage 3: capture rates and magnitudes
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                rate_s3_reg[i]  <= wq[i];
                arate_s3_reg[i] <= wq[i][SW-1] ? SW'(-wq[i]) : wq[i];
            end
            lim_s3_reg <= whit[0] | whit[1] | whit[2] | whit[3];
        end
    end

    // stage 4: largest magnitude
    assign max01 = (arate_s3_reg[0] > arate_s3_reg[1]) ? arate_s3_reg[0] : arate_s3_reg[1];
    assign max23 = (arate_s3_reg[2] > arate_s3_reg[3]) ? arate_s3_reg[2] : arate_s3_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rate_s4_reg  <= rate_s3_reg;
            arate_s4_reg <= arate_s3_reg;
            peak_s4_reg  <= (max01 > max23) ? max01 : max23;
            lim_s4_reg   <= lim_s3_reg;
        end
    end

    // stage 5: scale decision and magnitude times limit
    assign scl_next = (limit_reg != '0) && (peak_s4_reg > SW'(limit_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                prod_s5_reg[i] <= fwoik_pkg::DN_W'(arate_s4_reg[i])
                                  * fwoik_pkg::DN_W'(limit_reg);
                sneg_s5_reg[i] <= rate_s4_reg[i][SW-1];
            end
            rate_s5_reg <= rate_s4_reg;
            peak_s5_reg <= peak_s4_reg;
            scl_s5_reg  <= scl_next;
            lim_s5_reg  <= lim_s4_reg;
        end
    end

    // scaling dividers
    for (genvar g = 0; g < NW; g++)
    begin : g_sdiv
        fwoik_div u_sdiv (
            .clk (clk),
            .en  (adv),
            .num (prod_s5_reg[g]),
            .den (fwoik_pkg::DD_W'(peak_s5_reg)),
            .neg (sneg_s5_reg[g]),
            .q   (sq[g]),
            .hit ()
        );
    end

    // side data alongside the scaling dividers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                sd_reg[0].rate[i] <= rate_s5_reg[i];
            end
            sd_reg[0].scl <= scl_s5_reg;
            sd_reg[0].lim <= lim_s5_reg;
            for (int k = 1; k < DL; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    // stage 6: pick scaled or raw rates
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                rate_s6_reg[i] <= sd_reg[DL-1].scl ? sq[i] : $signed(sd_reg[DL-1].rate[i]);
            end
            lim_s6_reg <= sd_reg[DL-1].lim | sd_reg[DL-1].scl;
        end
    end

    // stage 7: rate times diameter
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                p_s7_reg[i] <= rate_s6_reg[i] * $signed({1'b0, diam_reg[i]});
            end
            rate_s7_reg <= rate_s6_reg;
            lim_s7_reg  <= lim_s6_reg;
        end
    end

    // stage 8: body velocity sums
    always_comb
    begin
        for (int i = 0; i < NW; i++)
        begin
            t[i] = inv_reg[i] ? -ACHW'(p_s7_reg[i]) : ACHW'(p_s7_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            xn_s8_reg   <= t[0] - t[1] + t[2] - t[3];
            yn_s8_reg   <= t[2] + t[3] - t[0] - t[1];
            tot_s8_reg  <= t[0] + t[1] + t[2] + t[3];
            rate_s8_reg <= rate_s7_reg;
            lim_s8_reg  <= lim_s7_reg;
        end
    end

    // stage 9: round forward and sideways, prepare yaw division
    always_comb
    begin
        xm   = xn_s8_reg[ACHW-1] ? ACHW'(-xn_s8_reg) : xn_s8_reg;
        ym   = yn_s8_reg[ACHW-1] ? ACHW'(-yn_s8_reg) : yn_s8_reg;
        totm = tot_s8_reg[ACHW-1] ? ACHW'(-tot_s8_reg) : tot_s8_reg;
        xs   = fwoik_pkg::sat_mag(fwoik_pkg::WIDE_W'((xm + HALF8) >> SHR), xn_s8_reg[ACHW-1]);
        ys   = fwoik_pkg::sat_mag(fwoik_pkg::WIDE_W'((ym + HALF8) >> SHR), yn_s8_reg[ACHW-1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_s9_reg   <= xs.val;
            ay_s9_reg   <= ys.val;
            ynum_s9_reg <= fwoik_pkg::DN_W'(totm);
            yneg_s9_reg <= ~tot_s8_reg[ACHW-1];
            rate_s9_reg <= rate_s8_reg;
            lim_s9_reg  <= lim_s8_reg;
        end
    end

    // yaw divider over four times the span
    fwoik_div u_ydiv (
        .clk (clk),
        .en  (adv),
        .num (ynum_s9_reg),
        .den (fwoik_pkg::DD_W'({span, 2'b00})),
        .neg (yneg_s9_reg),
        .q   (yq),
        .hit ()
    );

    // side data alongside the yaw divider
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NW; i++)
            begin
                yd_reg[0].rate[i] <= rate_s9_reg[i];
            end
            yd_reg[0].lim <= lim_s9_reg;
            yd_reg[0].ax  <= ax_s9_reg;
            yd_reg[0].ay  <= ay_s9_reg;
            for (int k = 1; k < DL; k++)
            begin
                yd_reg[k] <= yd_reg[k-1];
            end
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res.wheel_rate_front_left  <= $signed(yd_reg[DL-1].rate[0]);
            res.wheel_rate_front_right <= $signed(yd_reg[DL-1].rate[1]);
            res.wheel_rate_back_left   <= $signed(yd_reg[DL-1].rate[2]);
            res.wheel_rate_back_right  <= $signed(yd_reg[DL-1].rate[3]);
            res.achieved_forward       <= $signed(yd_reg[DL-1].ax);
            res.achieved_sideways      <= $signed(yd_reg[DL-1].ay);
            res.achieved_yaw           <= yq;
            res.was_limited            <= yd_reg[DL-1].lim;
        end
    end

endmodule

`default_nettype wire
